@@ design/cds_pkg.sv @@
package cds_pkg;

  // Calendar span handled by the block.
  localparam int FIRST_YEAR = 1901;
  localparam int YEAR_SPAN  = 256;
  localparam int LAST_YEAR  = FIRST_YEAR + YEAR_SPAN - 1;

  // Field widths of the stream beats.
  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int IYEAR_W  = 12;
  localparam int OFF_W    = 18;
  localparam int DNO_W    = 17;
  localparam int WDAY_W   = 3;
  localparam int YEAR_W   = 13;
  localparam int LEN_W    = 9;
  localparam int IN_BITS  = 40;
  localparam int OUT_BITS = 48;

  function automatic bit is_leap(int y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  // Days in all whole years from the first year up to, not including, y.
  function automatic int days_before(int y);
    int sum;
    sum = 0;
    for (int k = FIRST_YEAR; k < y; k++) begin
      sum = sum + (is_leap(k) ? 366 : 365);
    end
    return sum;
  endfunction

  // Last day number of the span, and the widths that follow from it.
  localparam int SPAN_END = days_before(LAST_YEAR + 1);
  localparam int DN_W     = $clog2(SPAN_END + 1);
  localparam int ACC_W    = ((DN_W > OFF_W) ? DN_W : OFF_W) + 2;

  localparam int Y0_MOD4   = FIRST_YEAR % 4;
  localparam int Y0_MOD100 = FIRST_YEAR % 100;
  localparam int Y0_MOD400 = FIRST_YEAR % 400;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_YFWD,
    S_MFWD,
    S_SHIFT,
    S_RANGE,
    S_YBACK,
    S_MBACK,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLEAR,
    ACC_ADD,
    ACC_SUB
  } acc_op_t;

  typedef struct packed {
    acc_op_t             op;
    logic                wk_add;
    logic [WDAY_W-1:0]   wk_inc;
  } acc_ctrl_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] value;
    logic                    gt;
    logic [WDAY_W-1:0]       wk;
  } acc_stat_t;

  typedef struct packed {
    logic init;
    logic step;
  } yr_ctrl_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] day_offset;
    logic [IYEAR_W-1:0]      in_year;
    logic [MONTH_W-1:0]      in_month;
    logic [DAY_W-1:0]        in_day;
  } in_beat_t;

  typedef struct packed {
    logic                out_valid;
    logic [YEAR_W-1:0]   out_year;
    logic [MONTH_W-1:0]  out_month;
    logic [DAY_W-1:0]    out_day;
    logic [WDAY_W-1:0]   weekday;
    logic [DNO_W-1:0]    day_number;
    logic                in_valid;
  } res_beat_t;

  function automatic logic [DAY_W-1:0] month_len(logic [MONTH_W-1:0] m, logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

  // Residue mod 7 of a value below 32, by a short chain of compares.
  function automatic logic [WDAY_W-1:0] mod7_small(logic [DAY_W-1:0] v);
    logic [DAY_W-1:0] r;
    if (v >= 5'd28) begin
      r = v - 5'd28;
    end else if (v >= 5'd21) begin
      r = v - 5'd21;
    end else if (v >= 5'd14) begin
      r = v - 5'd14;
    end else if (v >= 5'd7) begin
      r = v - 5'd7;
    end else begin
      r = v;
    end
    return r[WDAY_W-1:0];
  endfunction

endpackage

@@ design/calendar_date_shift.sv @@
// Gregorian date checker, day-number converter and date shifter.
//
// Input beats arrive on s_tvalid/s_tready/s_tdata and carry a date and a
// signed day offset. Each input beat gives exactly one result beat on
// m_tvalid/m_tready/m_tdata: the check flag, the day number counted from
// 1 January 1901 (day 1), the weekday (0 Monday), the shifted date and its
// range flag. Fields of a rejected date read as zero.
//
// One adder-comparator is stepped by a sequencer: it walks the years from
// 1901 to the given year, then the months, adds the offset, and walks years
// and months again to take the shifted day number apart. A date with its year or
// month out of range, or with day zero, goes from the check straight to the
// final state. s_tready is high only while the sequencer is idle.
//
// The result waits in an output register; when the receiver stalls, the
// sequencer holds in its final state until that register is taken. Reset
// (rst, synchronous) returns to idle and drops any pending result beat.
module calendar_date_shift (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata, lowest bit up: in_day[4:0], in_month[8:5], in_year[20:9],
  // day_offset[38:21], zero pad.
  input  logic [cds_pkg::IN_BITS-1:0]     s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata, lowest bit up: in_valid[0], day_number[17:1], weekday[20:18],
  // out_day[25:21], out_month[29:26], out_year[42:30], out_valid[43], zero pad.
  output logic [cds_pkg::OUT_BITS-1:0]    m_tdata
);
  import cds_pkg::*;

  state_t                  state;
  state_t                  state_next;
  in_beat_t                item;
  in_beat_t                s_beat;
  res_beat_t               res;
  logic [MONTH_W-1:0]      mcur;
  logic [DNO_W-1:0]        dn17;
  logic [WDAY_W-1:0]       wk_reg;
  logic                    date_ok;
  logic                    shift_ok;
  acc_ctrl_t               acc_ctrl;
  acc_stat_t               acc_stat;
  logic signed [ACC_W-1:0] operand;
  yr_ctrl_t                yr_ctrl;
  logic [YEAR_W-1:0]       ycur;
  logic                    leap;
  logic [DAY_W-1:0]        cur_mlen;
  logic [LEN_W-1:0]        cur_ylen;
  logic                    bad_fields;
  logic                    at_year;
  logic                    at_month;
  logic                    bad_day;
  logic                    out_range;
  logic                    s_fire;
  logic                    out_free;

  cds_year_ctr u_year (
    .clk  (clk),
    .ctrl (yr_ctrl),
    .year (ycur),
    .leap (leap)
  );

  cds_accum u_acc (
    .clk     (clk),
    .ctrl    (acc_ctrl),
    .operand (operand),
    .stat    (acc_stat)
  );

  // Decode of the stored item and of the current calendar position.
  assign s_beat     = in_beat_t'(s_tdata[$bits(in_beat_t)-1:0]);
  assign s_fire     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign cur_mlen   = month_len(mcur, leap);
  assign cur_ylen   = leap ? 9'd366 : 9'd365;
  assign bad_fields = ({1'b0, item.in_year} < YEAR_W'(FIRST_YEAR)) ||
                      ({1'b0, item.in_year} > YEAR_W'(LAST_YEAR)) ||
                      (item.in_month == 4'd0) || (item.in_month > 4'd12) ||
                      (item.in_day == 5'd0);
  assign at_year    = (ycur == {1'b0, item.in_year});
  assign at_month   = (mcur == item.in_month);
  assign bad_day    = (item.in_day > month_len(item.in_month, leap));
  assign out_range  = (acc_stat.value < ACC_W'(1)) || acc_stat.gt;

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_fire) state_next = S_CHECK;
      S_CHECK: state_next = bad_fields ? S_DONE : S_YFWD;
      S_YFWD: begin
        if (at_year) begin
          state_next = bad_day ? S_DONE : S_MFWD;
        end
      end
      S_MFWD:  if (at_month) state_next = S_SHIFT;
      S_SHIFT: state_next = S_RANGE;
      S_RANGE: state_next = out_range ? S_DONE : S_YBACK;
      S_YBACK: if (!acc_stat.gt) state_next = S_MBACK;
      S_MBACK: if (!acc_stat.gt) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control of the shared unit and the year counter.
  always_comb begin
    s_tready        = 1'b0;
    acc_ctrl.op     = ACC_HOLD;
    acc_ctrl.wk_add = 1'b0;
    acc_ctrl.wk_inc = '0;
    operand         = '0;
    yr_ctrl.init    = 1'b0;
    yr_ctrl.step    = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready     = 1'b1;
        acc_ctrl.op  = ACC_CLEAR;
        yr_ctrl.init = 1'b1;
      end
      S_YFWD: begin
        operand = ACC_W'(cur_ylen);
        if (!at_year) begin
          acc_ctrl.op     = ACC_ADD;
          acc_ctrl.wk_add = 1'b1;
          acc_ctrl.wk_inc = leap ? 3'd2 : 3'd1;
          yr_ctrl.step    = 1'b1;
        end
      end
      S_MFWD: begin
        acc_ctrl.op     = ACC_ADD;
        acc_ctrl.wk_add = 1'b1;
        if (at_month) begin
          operand         = ACC_W'(item.in_day);
          acc_ctrl.wk_inc = mod7_small(item.in_day);
        end else begin
          operand         = ACC_W'(cur_mlen);
          acc_ctrl.wk_inc = mod7_small(cur_mlen);
        end
      end
      S_SHIFT: begin
        acc_ctrl.op = ACC_ADD;
        operand     = {{(ACC_W - OFF_W){item.day_offset[OFF_W-1]}}, item.day_offset};
      end
      S_RANGE: begin
        operand      = ACC_W'(SPAN_END);
        yr_ctrl.init = 1'b1;
      end
      S_YBACK: begin
        operand = ACC_W'(cur_ylen);
        if (acc_stat.gt) begin
          acc_ctrl.op  = ACC_SUB;
          yr_ctrl.step = 1'b1;
        end
      end
      S_MBACK: begin
        operand = ACC_W'(cur_mlen);
        if (acc_stat.gt) begin
          acc_ctrl.op = ACC_SUB;
        end
      end
      default: begin
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Item registers, month counter and result flags.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (s_fire) begin
          item     <= s_beat;
          date_ok  <= 1'b0;
          shift_ok <= 1'b0;
        end
      end
      S_CHECK: date_ok <= !bad_fields;
      S_YFWD: begin
        if (at_year) begin
          date_ok <= !bad_day;
          mcur    <= 4'd1;
        end
      end
      S_MFWD:  if (!at_month) mcur <= mcur + 1'b1;
      S_SHIFT: begin
        dn17   <= DNO_W'(acc_stat.value);
        wk_reg <= acc_stat.wk;
      end
      S_RANGE: begin
        shift_ok <= !out_range;
        mcur     <= 4'd1;
      end
      S_MBACK: if (acc_stat.gt) mcur <= mcur + 1'b1;
      default: begin
      end
    endcase
  end

  // Result fields; a rejected date or shift reads as zero.
  always_comb begin
    res            = '0;
    res.in_valid   = date_ok;
    if (date_ok) begin
      res.day_number = dn17;
      res.weekday    = wk_reg;
      if (shift_ok) begin
        res.out_day   = DAY_W'(acc_stat.value);
        res.out_month = mcur;
        res.out_year  = ycur;
        res.out_valid = 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_tdata <= OUT_BITS'(res);
    end
  end

  // A finished result waits while the output register is still occupied.
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && m_tvalid && !m_tready) |=> (state == S_DONE))
    else $error("result overwrote a pending beat");

  // A shifted date is only flagged for a date that passed the check.
  a_valid_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[43]) |-> m_tdata[0])
    else $error("out_valid without in_valid");

  // A flagged shifted date carries a real month.
  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[43]) |-> (m_tdata[29:26] != 4'd0 && m_tdata[29:26] <= 4'd12))
    else $error("shifted month out of range");

  // The month walk backward never runs past December.
  a_mback_month: assert property (@(posedge clk) disable iff (rst)
    (state == S_MBACK) |-> (mcur != 4'd0 && mcur <= 4'd12))
    else $error("month counter out of range");

  // An accepted beat starts the check in the next cycle.
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> (state == S_CHECK))
    else $error("accepted beat did not start the sequence");

endmodule

@@ design/cds_year_ctr.sv @@
module cds_year_ctr (
  input  logic                      clk,
  input  cds_pkg::yr_ctrl_t         ctrl,
  output logic [cds_pkg::YEAR_W-1:0] year,
  output logic                      leap
);
  import cds_pkg::*;

  logic [1:0] mod4;
  logic [6:0] mod100;
  logic [8:0] mod400;

  // Year counter with running residues, so the leap rule needs no divider.
  always_ff @(posedge clk) begin
    if (ctrl.init) begin
      year   <= YEAR_W'(FIRST_YEAR);
      mod4   <= 2'(Y0_MOD4);
      mod100 <= 7'(Y0_MOD100);
      mod400 <= 9'(Y0_MOD400);
    end else if (ctrl.step) begin
      year   <= year + 1'b1;
      mod4   <= mod4 + 1'b1;
      mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 1'b1;
      mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 1'b1;
    end
  end

  assign leap = (mod400 == 9'd0) || ((mod100 != 7'd0) && (mod4 == 2'd0));

endmodule

@@ design/cds_accum.sv @@
module cds_accum (
  input  logic                             clk,
  input  cds_pkg::acc_ctrl_t               ctrl,
  input  logic signed [cds_pkg::ACC_W-1:0] operand,
  output cds_pkg::acc_stat_t               stat
);
  import cds_pkg::*;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] addend;
  logic signed [ACC_W-1:0] sum;
  logic [WDAY_W-1:0]       wk;
  logic [WDAY_W:0]         wk_sum;
  logic [WDAY_W-1:0]       wk_next;
  logic                    sub;

  // The one adder of the block: add or subtract the selected operand.
  assign sub    = (ctrl.op == ACC_SUB);
  assign addend = sub ? ~operand : operand;
  assign sum    = acc + addend + ACC_W'(sub);

  // Weekday residue follows every forward add that counts calendar days.
  assign wk_sum  = {1'b0, wk} + {1'b0, ctrl.wk_inc};
  assign wk_next = (wk_sum >= 4'd7) ? WDAY_W'(wk_sum - 4'd7) : wk_sum[WDAY_W-1:0];

  always_ff @(posedge clk) begin
    case (ctrl.op)
      ACC_CLEAR: begin
        acc <= '0;
        wk  <= '0;
      end
      ACC_ADD: begin
        acc <= sum;
        if (ctrl.wk_add) begin
          wk <= wk_next;
        end
      end
      ACC_SUB: begin
        acc <= sum;
      end
      default: begin
      end
    endcase
  end

  assign stat.value = acc;
  assign stat.gt    = (acc > operand);
  assign stat.wk    = wk;

endmodule
